>>> sv/ps2mc_pkg.sv
// ----------------------------------------------------------------------------
// ps2mc_pkg: shared types and constants of the PS/2 mouse cursor block
// Holds the item, result and configuration types, the operation and register
// codes, and the clamp and halving helpers used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mc_pkg;

   // Operation codes of an input item.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_SET  = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ABS_MODE     = 2'd0;
   localparam logic [1:0] CSR_GRID_COLUMNS = 2'd1;
   localparam logic [1:0] CSR_GRID_ROWS    = 2'd2;

   // Reset values.
   localparam logic [7:0] GRID_COLUMNS_RESET = 8'd80;
   localparam logic [7:0] GRID_ROWS_RESET    = 8'd25;
   localparam logic [7:0] COL_POS_RESET      = 8'd40;
   localparam logic [7:0] ROW_POS_RESET      = 8'd12;

   // Byte positions inside a packet.
   localparam logic [2:0] IDX_FIRST    = 3'd0;
   localparam logic [2:0] IDX_SECOND   = 3'd1;
   localparam logic [2:0] IDX_REL_LAST = 3'd2;
   localparam logic [2:0] IDX_ABS_LAST = 3'd4;

   // Flag byte bits of a relative packet.
   localparam int FLAG_SYNC_BIT = 3;
   localparam int FLAG_XSIGN_BIT = 4;
   localparam int FLAG_YSIGN_BIT = 5;

   // Absolute coordinates are scaled by grid size / 32768.
   localparam int ABS_SCALE_SHIFT = 15;

   typedef struct packed {
      logic              op;
      logic [7:0]        data_byte;
      logic              from_aux;
      logic signed [10:0] set_col;
      logic signed [10:0] set_row;
   } req_item_type;

   typedef struct packed {
      logic [7:0] cursor_col;
      logic [7:0] cursor_row;
      logic [2:0] buttons;
      logic [1:0] released;
      logic       moved;
      logic       packet_done;
   } result_type;

   typedef struct packed {
      logic       abs_mode;
      logic [7:0] grid_columns;
      logic [7:0] grid_rows;
      logic       mode_written;
   } cfg_type;

   // Clamp a signed coordinate into 0 .. max(size, 1) - 1.
   function automatic logic [7:0] clamp_to(input logic signed [11:0] v,
                                           input logic [7:0] size);
      logic [7:0] top;
      top = (size == 8'd0) ? 8'd0 : size - 8'd1;
      if (v[11]) begin
         return 8'd0;
      end
      if (v[10:0] > {3'b000, top}) begin
         return top;
      end
      return v[7:0];
   endfunction

   // Halve a signed value, rounding toward zero.
   function automatic logic signed [9:0] half_toward_zero(input logic signed [9:0] v);
      logic signed [9:0] biased;
      biased = v + {9'd0, v[9]};
      return biased >>> 1;
   endfunction

endpackage

`default_nettype wire

>>> sv/ps2mc_req_if.sv
// ----------------------------------------------------------------------------
// ps2mc_req_if: request channel
// Valid/ready channel carrying one controller byte or set-position request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2mc_req_if ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [7:0]        data_byte;
   logic              from_aux;
   logic signed [10:0] set_col;
   logic signed [10:0] set_row;

   modport source (output valid, output op, output data_byte, output from_aux,
                   output set_col, output set_row, input ready);
   modport sink   (input valid, input op, input data_byte, input from_aux,
                   input set_col, input set_row, output ready);
endinterface

`default_nettype wire

>>> sv/ps2mc_rsp_if.sv
// ----------------------------------------------------------------------------
// ps2mc_rsp_if: result channel
// Valid/ready channel carrying the cursor and button state after an item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2mc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] cursor_col;
   logic [7:0] cursor_row;
   logic [2:0] buttons;
   logic [1:0] released;
   logic       moved;
   logic       packet_done;

   modport source (output valid, output cursor_col, output cursor_row, output buttons,
                   output released, output moved, output packet_done, input ready);
   modport sink   (input valid, input cursor_col, input cursor_row, input buttons,
                   input released, input moved, input packet_done, output ready);
endinterface

`default_nettype wire

>>> sv/ps2mc_csr.sv
// ----------------------------------------------------------------------------
// ps2mc_csr: configuration registers
// Holds the mode and grid size and flags a write of the mode register.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mc_csr import ps2mc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wr_data,
   output cfg_type         cfg
);

   logic       abs_mode_ff;
   logic [7:0] grid_columns_ff;
   logic [7:0] grid_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_mode_ff     <= 1'b0;
         grid_columns_ff <= GRID_COLUMNS_RESET;
         grid_rows_ff    <= GRID_ROWS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ABS_MODE:     abs_mode_ff     <= csr_wr_data[0];
            CSR_GRID_COLUMNS: grid_columns_ff <= csr_wr_data;
            CSR_GRID_ROWS:    grid_rows_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign cfg.abs_mode     = abs_mode_ff;
   assign cfg.grid_columns = grid_columns_ff;
   assign cfg.grid_rows    = grid_rows_ff;
   // A mode write restarts packet gathering.
   assign cfg.mode_written = csr_wr_en && (csr_index == CSR_ABS_MODE);

endmodule

`default_nettype wire

>>> sv/ps2mc_core.sv
// ----------------------------------------------------------------------------
// ps2mc_core: packet decoder and cursor state
// Computes the result of the staged item and updates the packet and cursor
// state when that item moves on to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mc_core import ps2mc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   advance,
   input  req_item_type item,
   input  cfg_type     cfg,
   output result_type  result
);

   logic [2:0] byte_index_ff, byte_index_in;
   logic [2:0] held_ff, held_in;
   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] packet_ff [4];

   logic       pkt_we;
   logic [1:0] pkt_addr;
   logic       done;
   logic [2:0] rel_index;

   logic [7:0]         flags;
   logic signed [9:0]  dx, ndy, half_dx, half_dy;
   logic signed [11:0] rel_col, rel_row;
   logic [23:0]        abs_x_prod, abs_y_prod;
   logic [7:0]         abs_col, abs_row;
   logic [7:0]         set_col_c, set_row_c;
   logic [7:0]         rel_col_c, rel_row_c;

   assign flags = packet_ff[0];

   // Relative deltas: 9-bit two's complement, Y negated, halved toward zero.
   always_comb begin
      dx      = {flags[FLAG_XSIGN_BIT], flags[FLAG_XSIGN_BIT], packet_ff[1]};
      ndy     = -$signed({flags[FLAG_YSIGN_BIT], flags[FLAG_YSIGN_BIT], item.data_byte});
      half_dx = half_toward_zero(dx);
      half_dy = half_toward_zero(ndy);
      rel_col = $signed({4'd0, col_ff}) + {{2{half_dx[9]}}, half_dx};
      rel_row = $signed({4'd0, row_ff}) + {{2{half_dy[9]}}, half_dy};
   end

   // Absolute coordinates scaled into the grid.
   assign abs_x_prod = {packet_ff[2], packet_ff[1]} * cfg.grid_columns;
   assign abs_y_prod = {item.data_byte, packet_ff[3]} * cfg.grid_rows;

   always_comb begin
      abs_col   = clamp_to({3'd0, abs_x_prod[23:ABS_SCALE_SHIFT]}, cfg.grid_columns);
      abs_row   = clamp_to({3'd0, abs_y_prod[23:ABS_SCALE_SHIFT]}, cfg.grid_rows);
      set_col_c = clamp_to({item.set_col[10], item.set_col}, cfg.grid_columns);
      set_row_c = clamp_to({item.set_row[10], item.set_row}, cfg.grid_rows);
      rel_col_c = clamp_to(rel_col, cfg.grid_columns);
      rel_row_c = clamp_to(rel_row, cfg.grid_rows);
   end

   always_comb begin
      byte_index_in = byte_index_ff;
      held_in       = held_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      pkt_we        = 1'b0;
      pkt_addr      = byte_index_ff[1:0];
      done          = 1'b0;
      rel_index     = (byte_index_ff > IDX_REL_LAST) ? IDX_FIRST : byte_index_ff;

      priority if (item.op == OP_SET) begin
         col_in = set_col_c;
         row_in = set_row_c;
      end else if (item.from_aux) begin
         if (cfg.abs_mode) begin
            if (byte_index_ff < IDX_ABS_LAST) begin
               pkt_we        = 1'b1;
               byte_index_in = byte_index_ff + 3'd1;
            end else begin
               byte_index_in = IDX_FIRST;
               done          = 1'b1;
               held_in       = flags[2:0];
               col_in        = abs_col;
               row_in        = abs_row;
            end
         end else begin
            pkt_addr = rel_index[1:0];
            unique case (rel_index)
               IDX_FIRST: begin
                  // Resynchronize: a first byte must carry the sync bit.
                  if (item.data_byte[FLAG_SYNC_BIT]) begin
                     pkt_we        = 1'b1;
                     byte_index_in = IDX_SECOND;
                  end else begin
                     byte_index_in = IDX_FIRST;
                  end
               end
               IDX_SECOND: begin
                  pkt_we        = 1'b1;
                  byte_index_in = IDX_REL_LAST;
               end
               default: begin
                  pkt_we        = 1'b1;
                  byte_index_in = IDX_FIRST;
                  done          = 1'b1;
                  held_in       = flags[2:0];
                  col_in        = rel_col_c;
                  row_in        = rel_row_c;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= IDX_FIRST;
         held_ff       <= 3'd0;
         col_ff        <= COL_POS_RESET;
         row_ff        <= ROW_POS_RESET;
      end else if (cfg.mode_written) begin
         byte_index_ff <= IDX_FIRST;
      end else if (advance) begin
         byte_index_ff <= byte_index_in;
         held_ff       <= held_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && pkt_we) begin
         packet_ff[pkt_addr] <= item.data_byte;
      end
   end

   assign result.cursor_col  = col_in;
   assign result.cursor_row  = row_in;
   assign result.buttons     = held_in;
   assign result.released    = done ? (held_ff[1:0] & ~held_in[1:0]) : 2'd0;
   assign result.moved       = (col_in != col_ff) || (row_in != row_ff);
   assign result.packet_done = done;

endmodule

`default_nettype wire

>>> sv/ps2mc_top.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_top: PS/2 mouse packet decoder with grid cursor
// Decodes relative or absolute mouse packets into a clamped character-grid
// cursor, button state and release clicks; one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

// The block accepts one request per clock cycle while the result side keeps
// up, and returns exactly one result per request, in order. A request is
// captured in an input register; the decoder works on it from there, and when
// the result register is free or being emptied the result is captured in it
// together with the updated cursor and packet state. A stream of requests
// runs at one per cycle for as long as the result side takes one per cycle.
// The input register accepts a new request while a finished result still
// waits, and the request side stalls only when both registers are full.
// Controller bytes without from_aux produce a result that reports the
// unchanged state. In relative mode three-byte packets are gathered; a first
// byte without bit 3 set is dropped, which resynchronizes the packet stream.
// In absolute mode five-byte packets are gathered and the 16-bit coordinates
// are scaled by grid size / 32768. A set-position request clamps its
// coordinates into the grid and leaves the packet gathering alone. A grid size
// of zero behaves as one. Writes to the configuration registers must be made
// only while the block is idle; the block itself does not enforce this. Writing
// the mode register restarts packet gathering. The four-byte packet store has
// no reset; it is always written before it is read within a packet.

module ps2_mouse_packet_cursor_top import ps2mc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   ps2mc_req_if.sink       req_chan,
   ps2mc_rsp_if.source     rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wr_data
);

   cfg_type      cfg;
   req_item_type item_ff;
   logic         item_valid_ff;
   result_type   result;
   result_type   result_ff;
   logic         rsp_valid_ff;
   logic         advance;

   // The staged request moves on when the result register is free or is being
   // emptied in this cycle.
   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;

   ps2mc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ps2mc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.op        <= req_chan.op;
         item_ff.data_byte <= req_chan.data_byte;
         item_ff.from_aux  <= req_chan.from_aux;
         item_ff.set_col   <= req_chan.set_col;
         item_ff.set_row   <= req_chan.set_row;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cursor_col  = result_ff.cursor_col;
   assign rsp_chan.cursor_row  = result_ff.cursor_row;
   assign rsp_chan.buttons     = result_ff.buttons;
   assign rsp_chan.released    = result_ff.released;
   assign rsp_chan.moved       = result_ff.moved;
   assign rsp_chan.packet_done = result_ff.packet_done;

`ifndef SYNTHESIS
   // Release clicks are only reported by a completed packet.
   a_release_needs_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (result_ff.released == 2'd0 || result_ff.packet_done))
      else $error("release reported without a completed packet");

   // A released button must have been dropped from the held set.
   a_release_not_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((result_ff.released & result_ff.buttons[1:0]) == 2'd0))
      else $error("released button still reported as held");

   // A staged request that cannot move on stays staged.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("staged request lost while stalled");

   // Every request that moves on shows up as a pending result.
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result missing after advance");

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !item_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

>>> bench/ps2_mouse_packet_cursor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_top_tb: self-checking bench for the PS/2 cursor block
// Drives controller bytes and set-position requests through the request
// channel, predicts every result with a shadow decoder and compares each
// returned transfer field by field. A short directed table comes first, then
// random packet streams under several grid and mode settings.
// ----------------------------------------------------------------------------

module ps2_mouse_packet_cursor_top_tb import ps2mc_pkg::*; ();

   // Run shape. The cycle limit is far above the slowest legal run, even under
   // heavy stalling.
   localparam int CYCLE_LIMIT       = 200000;
   localparam int SEGMENTS          = 12;
   localparam int ITEMS_PER_SEGMENT = 68;
   localparam int DRAIN_CYCLES      = 8;
   localparam int REPORT_LIMIT      = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [7:0] csr_wr_data;

   ps2mc_req_if req_chan ();
   ps2mc_rsp_if rsp_chan ();

   ps2_mouse_packet_cursor_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Shadow copy of the decoder: configuration, packet gathering and cursor.
   // It is advanced at the rising edge of every request transfer and of every
   // register write, so it always matches what the block should hold.
   logic       mode_abs   = 1'b0;
   logic [7:0] grid_cols  = GRID_COLUMNS_RESET;
   logic [7:0] grid_rows  = GRID_ROWS_RESET;
   logic [2:0] gather_idx = IDX_FIRST;
   logic [7:0] packet_buf [0:3];
   logic [2:0] held_btns  = 3'd0;
   logic [7:0] cur_col    = COL_POS_RESET;
   logic [7:0] cur_row    = ROW_POS_RESET;

   // Results still owed by the block, oldest first.
   result_type expected_cursor_q [$];

   int error_count  = 0;
   int result_count = 0;
   int cycle_count  = 0;

   // Idle behavior. Percentages are changed by the stimulus between phases.
   int send_idle_pct  = 16;
   int recv_stall_pct = 72;

   // A directed row may carry a result typed in by hand. While such a row is
   // on the channel, pin_en is set and the typed result replaces the
   // prediction in the queue of owed results.
   bit         pin_en = 1'b0;
   result_type pin_want;

   typedef struct {
      bit            is_csr;
      logic [1:0]    csr_idx;
      logic [7:0]    csr_val;
      req_item_type  item;
      bit            pinned;
      result_type    want;
   } directed_row_type;

   directed_row_type directed_rows [$];

   // Clamp into 0 .. size-1, where a size of zero acts as one.
   function automatic logic [7:0] clamp_grid(input int v, input logic [7:0] size);
      int top;
      top = (size == 8'd0) ? 0 : int'(size) - 1;
      if (v < 0) return 8'd0;
      if (v > top) return top[7:0];
      return v[7:0];
   endfunction

   // Advance the shadow decoder by one request and return the result it owes.
   function automatic result_type predict_cursor_update(input req_item_type it);
      result_type r;
      logic [7:0] flags;
      logic       done;
      int         nc, nr, dx, dy;
      flags      = 8'h00;
      done       = 1'b0;
      nc         = int'(cur_col);
      nr         = int'(cur_row);
      r.released = 2'b00;
      if (it.op == OP_SET) begin
         nc = int'(clamp_grid(int'($signed(it.set_col)), grid_cols));
         nr = int'(clamp_grid(int'($signed(it.set_row)), grid_rows));
      end else if (it.from_aux && mode_abs) begin
         if (gather_idx < IDX_ABS_LAST) begin
            packet_buf[gather_idx[1:0]] = it.data_byte;
            gather_idx = gather_idx + 3'd1;
         end else begin
            // Coordinates are scaled by size / 32768 and rounded down.
            nc = int'(clamp_grid(int'({packet_buf[2], packet_buf[1]}) * int'(grid_cols)
                                 / 32768, grid_cols));
            nr = int'(clamp_grid(int'({it.data_byte, packet_buf[3]}) * int'(grid_rows)
                                 / 32768, grid_rows));
            flags      = packet_buf[0];
            done       = 1'b1;
            gather_idx = IDX_FIRST;
         end
      end else if (it.from_aux) begin
         if (gather_idx > IDX_REL_LAST) gather_idx = IDX_FIRST;
         case (gather_idx)
            IDX_FIRST: begin
               // Without the sync bit the byte is dropped.
               if (it.data_byte[FLAG_SYNC_BIT]) begin
                  packet_buf[0] = it.data_byte;
                  gather_idx    = IDX_SECOND;
               end
            end
            IDX_SECOND: begin
               packet_buf[1] = it.data_byte;
               gather_idx    = IDX_REL_LAST;
            end
            default: begin
               flags         = packet_buf[0];
               packet_buf[2] = it.data_byte;
               gather_idx    = IDX_FIRST;
               done          = 1'b1;
               dx = int'(packet_buf[1]) - (flags[FLAG_XSIGN_BIT] ? 256 : 0);
               dy = -(int'(it.data_byte) - (flags[FLAG_YSIGN_BIT] ? 256 : 0));
               // Integer division truncates toward zero.
               nc = int'(clamp_grid(int'(cur_col) + dx / 2, grid_cols));
               nr = int'(clamp_grid(int'(cur_row) + dy / 2, grid_rows));
            end
         endcase
      end
      if (done) begin
         r.released = held_btns[1:0] & ~flags[1:0];
         held_btns  = flags[2:0];
      end
      r.moved       = (nc != int'(cur_col)) || (nr != int'(cur_row));
      cur_col       = nc[7:0];
      cur_row       = nr[7:0];
      r.cursor_col  = cur_col;
      r.cursor_row  = cur_row;
      r.buttons     = held_btns;
      r.packet_done = done;
      return r;
   endfunction

   // Request builders. Fields that the operation ignores get random values,
   // so the block is also checked for really ignoring them.
   function automatic req_item_type mouse_byte(input logic [7:0] data, input logic aux);
      req_item_type it;
      it.op        = OP_BYTE;
      it.data_byte = data;
      it.from_aux  = aux;
      it.set_col   = 11'($urandom_range(0, 2047));
      it.set_row   = 11'($urandom_range(0, 2047));
      return it;
   endfunction

   function automatic req_item_type set_pos(input int col, input int row);
      req_item_type it;
      it.op        = OP_SET;
      it.data_byte = 8'($urandom_range(0, 255));
      it.from_aux  = 1'($urandom_range(0, 1));
      it.set_col   = col[10:0];
      it.set_row   = row[10:0];
      return it;
   endfunction

   // Either anywhere in the signed 11-bit range or near the grid.
   function automatic int random_coord();
      if ($urandom_range(0, 1)) return int'($urandom_range(0, 2047)) - 1024;
      return int'($urandom_range(0, 300));
   endfunction

   function automatic logic [7:0] grid_size_for(input int seg);
      if (seg == 0) return 8'd255;
      if (seg == 1) return 8'd1;
      case ($urandom_range(0, 5))
         0: return 8'd255;
         1: return 8'd1;
         2: return 8'd0;
         default: return 8'($urandom_range(2, 100));
      endcase
   endfunction

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("result %0d: %s", result_count, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
   endtask

   // Offer one request, called and returning at a falling edge. Random idle
   // cycles with valid low come first; then the request is held until the
   // block takes it.
   task automatic send_request(input req_item_type it, input bit pin, input result_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.op        <= it.op;
      req_chan.data_byte <= it.data_byte;
      req_chan.from_aux  <= it.from_aux;
      req_chan.set_col   <= it.set_col;
      req_chan.set_row   <= it.set_row;
      req_chan.valid     <= 1'b1;
      pin_en   = pin;
      pin_want = want;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Register writes happen only once every owed result has come back, so
   // the block is idle. The enable is high for a single cycle and is low again
   // on return, so back-to-back writes never touch it twice in one time step.
   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      req_chan.valid <= 1'b0;
      while (expected_cursor_q.size() != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add_item_row(input req_item_type it, input bit pin, input result_type want);
      directed_row_type row;
      row.is_csr  = 1'b0;
      row.csr_idx = CSR_ABS_MODE;
      row.csr_val = 8'd0;
      row.item    = it;
      row.pinned  = pin;
      row.want    = want;
      directed_rows.push_back(row);
   endtask

   task automatic add_csr_row(input logic [1:0] idx, input logic [7:0] val);
      directed_row_type row;
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      row.item    = '0;
      row.pinned  = 1'b0;
      row.want    = '0;
      directed_rows.push_back(row);
   endtask

   // The result side stalls at random.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Watch both channels and the register port at every rising edge. A
   // request transfer pushes its predicted result; a result transfer is
   // checked against the oldest one still owed.
   always @(posedge clock) begin : watch_channels
      req_item_type accepted;
      result_type   predicted;
      result_type   owed;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ABS_MODE: begin
                  mode_abs   = csr_wr_data[0];
                  gather_idx = IDX_FIRST;
               end
               CSR_GRID_COLUMNS: grid_cols = csr_wr_data;
               CSR_GRID_ROWS:    grid_rows = csr_wr_data;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            accepted = {req_chan.op, req_chan.data_byte, req_chan.from_aux,
                        req_chan.set_col, req_chan.set_row};
            predicted = predict_cursor_update(accepted);
            if (pin_en) predicted = pin_want;
            expected_cursor_q.push_back(predicted);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_count++;
            if (expected_cursor_q.size() == 0) begin
               note_failure("result transfer with no request outstanding");
            end else begin
               owed = expected_cursor_q.pop_front();
               check_field("cursor_col", owed.cursor_col, rsp_chan.cursor_col);
               check_field("cursor_row", owed.cursor_row, rsp_chan.cursor_row);
               check_field("buttons", 8'(owed.buttons), 8'(rsp_chan.buttons));
               check_field("released", 8'(owed.released), 8'(rsp_chan.released));
               check_field("moved", 8'(owed.moved), 8'(rsp_chan.moved));
               check_field("packet_done", 8'(owed.packet_done), 8'(rsp_chan.packet_done));
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[ps2_mouse_packet_cursor_top] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int         counted;
      int         pick;
      int         plen;
      logic [7:0] b;

      csr_wr_en          = 1'b0;
      csr_index          = CSR_ABS_MODE;
      csr_wr_data        = 8'd0;
      req_chan.valid     = 1'b0;
      req_chan.op        = OP_BYTE;
      req_chan.data_byte = 8'd0;
      req_chan.from_aux  = 1'b0;
      req_chan.set_col   = 11'd0;
      req_chan.set_row   = 11'd0;

      // Directed table. Typed results list the fields in the order
      // column, row, buttons, released, moved, packet done.
      // Right after reset an ignored byte reports the reset cursor.
      add_item_row(mouse_byte(8'h08, 1'b0), 1'b1, {8'd40, 8'd12, 3'd0, 2'd0, 1'b0, 1'b0});
      // Set position at both ends of the signed range clamps to the grid.
      add_item_row(set_pos(1023, 1023), 1'b1, {8'd79, 8'd24, 3'd0, 2'd0, 1'b1, 1'b0});
      add_item_row(set_pos(-1024, -1024), 1'b1, {8'd0, 8'd0, 3'd0, 2'd0, 1'b1, 1'b0});
      // A first byte without the sync bit is dropped.
      add_item_row(mouse_byte(8'h00, 1'b1), 1'b1, {8'd0, 8'd0, 3'd0, 2'd0, 1'b0, 1'b0});
      // Largest positive X and most negative Y deltas, both clamped.
      add_item_row(mouse_byte(8'h0B, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'hFF, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'hFF, 1'b1), 1'b1, {8'd79, 8'd0, 3'd3, 2'd0, 1'b1, 1'b1});
      // Most negative X and positive Y; both held buttons are released.
      add_item_row(mouse_byte(8'h38, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'h00, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'h00, 1'b1), 1'b1, {8'd0, 8'd24, 3'd0, 2'd3, 1'b1, 1'b1});
      // Deltas of -1 and +1 halve to zero; middle button held.
      add_item_row(mouse_byte(8'h1C, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'hFF, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'h01, 1'b1), 1'b0, '0);
      // A grid of zero size behaves as a single cell.
      add_csr_row(CSR_GRID_COLUMNS, 8'd0);
      add_csr_row(CSR_GRID_ROWS, 8'd0);
      add_item_row(set_pos(5, 5), 1'b0, '0);
      add_csr_row(CSR_GRID_COLUMNS, 8'd255);
      add_csr_row(CSR_GRID_ROWS, 8'd255);
      add_item_row(set_pos(1023, 1023), 1'b0, '0);
      // After the grid shrinks the cursor stays outside it until an update.
      add_csr_row(CSR_GRID_COLUMNS, 8'd10);
      add_csr_row(CSR_GRID_ROWS, 8'd5);
      add_item_row(mouse_byte(8'h5A, 1'b0), 1'b0, '0);
      // Switching mode in the middle of a packet restarts gathering.
      add_item_row(mouse_byte(8'h08, 1'b1), 1'b0, '0);
      add_csr_row(CSR_ABS_MODE, 8'd1);
      add_item_row(mouse_byte(8'h03, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'hFF, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'hFF, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'hFF, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'hFF, 1'b1), 1'b0, '0);
      add_csr_row(CSR_ABS_MODE, 8'd0);
      add_item_row(mouse_byte(8'h08, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'h02, 1'b1), 1'b0, '0);
      add_item_row(mouse_byte(8'hFE, 1'b1), 1'b0, '0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         end else begin
            send_request(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);
         end
      end

      // Random part. Each segment sets a new mode and grid, then mostly sends
      // well-formed packets with random content; some packets are cut short
      // or have set-position requests and foreign bytes mixed in.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         send_idle_pct  = (seg < 4) ? 16 : (seg < 8) ? 72 : 0;
         recv_stall_pct = (seg < 4) ? 72 : (seg < 8) ? 16 : 0;
         write_csr(CSR_ABS_MODE, {7'd0, seg[0]});
         write_csr(CSR_GRID_COLUMNS, grid_size_for(seg));
         write_csr(CSR_GRID_ROWS, grid_size_for(seg));
         counted = 0;
         while (counted < ITEMS_PER_SEGMENT) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               plen = mode_abs ? 5 : 3;
               for (int k = 0; k < plen; k++) begin
                  if (k != 0 && $urandom_range(0, 99) < 8) begin
                     if ($urandom_range(0, 1)) begin
                        send_request(set_pos(random_coord(), random_coord()), 1'b0, '0);
                     end else begin
                        send_request(mouse_byte(8'($urandom_range(0, 255)), 1'b0), 1'b0, '0);
                     end
                     counted++;
                  end
                  if (k != 0 && $urandom_range(0, 99) < 3) break;
                  b = 8'($urandom_range(0, 255));
                  if (k == 0 && !mode_abs) b[FLAG_SYNC_BIT] = 1'b1;
                  send_request(mouse_byte(b, 1'b1), 1'b0, '0);
                  counted++;
               end
            end else if (pick < 85) begin
               send_request(set_pos(random_coord(), random_coord()), 1'b0, '0);
               counted++;
            end else if (pick < 93) begin
               send_request(mouse_byte(8'($urandom_range(0, 255)), 1'b0), 1'b0, '0);
               counted++;
            end else begin
               send_request(mouse_byte(8'($urandom_range(0, 255)), 1'b1), 1'b0, '0);
               counted++;
            end
         end
      end

      // Let every owed result come back, then go on watching the quiet result
      // channel so that any stray result transfer can still show up.
      req_chan.valid <= 1'b0;
      while (expected_cursor_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ps2_mouse_packet_cursor_top] OK");
      end else begin
         $display("[ps2_mouse_packet_cursor_top] ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/ps2mc_pkg.sv
sv/ps2mc_req_if.sv
sv/ps2mc_rsp_if.sv
sv/ps2mc_csr.sv
sv/ps2mc_core.sv
sv/ps2mc_top.sv
bench/ps2_mouse_packet_cursor_top_tb.sv
